// File: design/acpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_pkg
// Shared types and constants of the attribute-cell pixel renderer.
// ----------------------------------------------------------------------------
package acpr_pkg;

  localparam int PIX_W      = 8;   // pixel bits per microline
  localparam int LANES      = 8;   // microlines per cell
  localparam int BIT_IDX_W  = 3;   // index over the bits of one microline
  localparam int COLOR_W    = 4;
  localparam int POS_W      = 8;

  // attribute byte layout
  localparam int ATTR_INK_LSB   = 0;
  localparam int ATTR_PAPER_LSB = 3;
  localparam int ATTR_BRIGHT    = 6;
  localparam int ATTR_FLASH     = 7;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic [7:0] attr_byte;
    logic [7:0] row0_bits;
    logic [7:0] row1_bits;
    logic [7:0] row2_bits;
    logic [7:0] row3_bits;
    logic [7:0] row4_bits;
    logic [7:0] row5_bits;
    logic [7:0] row6_bits;
    logic [7:0] row7_bits;
  } cell_in_t;

  typedef struct packed {
    logic [7:0] strip_x;
    logic [7:0] strip_y;
    logic [3:0] pix0_color;
    logic [3:0] pix1_color;
    logic [3:0] pix2_color;
    logic [3:0] pix3_color;
    logic [3:0] pix4_color;
    logic [3:0] pix5_color;
    logic [3:0] pix6_color;
    logic [3:0] pix7_color;
    logic       cell_last;
    logic       frame_end;
  } strip_out_t;

  // placement and flags of one strip, from the cell stage to the merge stage
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             cell_last;
    logic             frame_end;
  } strip_tag_t;

endpackage

// File: design/acpr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_lane
// One microline lane: picks ink or paper for the selected pixel bit.
// ----------------------------------------------------------------------------
module acpr_lane (
  input  logic [acpr_pkg::PIX_W-1:0]     row_bits,
  input  logic [acpr_pkg::BIT_IDX_W-1:0] bit_idx,
  input  acpr_pkg::color_t               set_color,
  input  acpr_pkg::color_t               clear_color,
  output acpr_pkg::color_t               color
);
  import acpr_pkg::*;

  assign color = row_bits[bit_idx] ? set_color : clear_color;

endmodule

// File: design/acpr_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpr_merge
// Combines the eight lane colors with the strip tag into one result and
// holds it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module acpr_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 strip_valid,
  input  acpr_pkg::strip_tag_t tag,
  input  acpr_pkg::color_t     lane_color [acpr_pkg::LANES],
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output acpr_pkg::strip_out_t out_data
);
  import acpr_pkg::*;

  strip_out_t strip;

  assign ready = !out_valid || !out_stall;

  always_comb begin
    strip.strip_x    = tag.x;
    strip.strip_y    = tag.y;
    strip.pix0_color = lane_color[0];
    strip.pix1_color = lane_color[1];
    strip.pix2_color = lane_color[2];
    strip.pix3_color = lane_color[3];
    strip.pix4_color = lane_color[4];
    strip.pix5_color = lane_color[5];
    strip.pix6_color = lane_color[6];
    strip.pix7_color = lane_color[7];
    strip.cell_last  = tag.cell_last;
    strip.frame_end  = tag.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= strip_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && strip_valid) begin
      out_data <= strip;
    end
  end

endmodule

// File: design/attribute_cell_pixel_render.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_cell_pixel_render
// Renders 8x8 attribute cells into vertical strips of 4-bit color indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transaction per
//   character cell, the attribute byte plus eight pixel-row bytes.
//   Output channel (out_valid / out_stall / out_data): eight transactions per
//   cell, one strip per bit position, LSB first, each with eight colors.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes flash_phase;
//   cfg_ready is always high. Write it only while the block is idle.
//   The first strip of a cell passes the cell stage and then the output
//   register. One strip per cycle while the output is not stalled; the cell
//   stage steps its bit counter once per strip and takes the next cell in
//   the same cycle as the last strip of the current one leaves it.
//   A stall on the output holds the output register and the cell stage;
//   in_stall then rises once a cell is waiting in the cell stage.
//   Reset clears the column and text-row counters, flash_phase and all
//   valid flags. Positions wrap over CELLS_PER_ROW by ROWS_PER_SCREEN cells.
// ----------------------------------------------------------------------------
module attribute_cell_pixel_render #(
  parameter int CELLS_PER_ROW   = 32,
  parameter int ROWS_PER_SCREEN = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  // cell input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  acpr_pkg::cell_in_t   in_data,
  // strip output
  output logic                 out_valid,
  input  logic                 out_stall,
  output acpr_pkg::strip_out_t out_data,
  // flash phase register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import acpr_pkg::*;

  localparam int COL_W = (CELLS_PER_ROW > 1) ? $clog2(CELLS_PER_ROW) : 1;
  localparam int ROW_W = (ROWS_PER_SCREEN > 1) ? $clog2(ROWS_PER_SCREEN) : 1;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(CELLS_PER_ROW - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_SCREEN - 1);

  // screen position counters and blink phase
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] text_row;
  logic             flash_phase;

  // cell stage: the cell being serialized into strips
  logic                 cell_valid;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic [PIX_W-1:0]     rows [LANES];
  color_t               set_color;
  color_t               clear_color;
  logic [COL_W-1:0]     cell_col;
  logic [ROW_W-1:0]     cell_row;
  logic                 cell_is_last;

  logic       merge_ready;
  logic       advance;
  logic       accept;
  logic       swap;
  color_t     ink;
  color_t     paper;
  color_t     lane_color [LANES];
  strip_tag_t tag;
  logic [COL_W+BIT_IDX_W-1:0] x_wide;

  assign cfg_ready = 1'b1;

  // one strip leaves the cell stage whenever the merge stage can take it
  assign advance  = cell_valid && merge_ready;
  // a new cell may enter as the last strip of the current one leaves
  assign in_stall = cell_valid && !(advance && (bit_idx == LAST_BIT));
  assign accept   = in_valid && !in_stall;

  // bright sets bit 3 of both colors; flash swaps them in phase 1
  assign ink   = {in_data.attr_byte[ATTR_BRIGHT], in_data.attr_byte[ATTR_INK_LSB +: 3]};
  assign paper = {in_data.attr_byte[ATTR_BRIGHT], in_data.attr_byte[ATTR_PAPER_LSB +: 3]};
  assign swap  = in_data.attr_byte[ATTR_FLASH] & flash_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_phase <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      flash_phase <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      bit_idx    <= '0;
      column     <= '0;
      text_row   <= '0;
    end else if (accept) begin
      cell_valid <= 1'b1;
      bit_idx    <= '0;
      if (column == LAST_COL) begin
        column <= '0;
        if (text_row == LAST_ROW) begin
          text_row <= '0;
        end else begin
          text_row <= text_row + 1'b1;
        end
      end else begin
        column <= column + 1'b1;
      end
    end else if (advance) begin
      if (bit_idx == LAST_BIT) begin
        cell_valid <= 1'b0;
      end
      bit_idx <= bit_idx + 1'b1;
    end
  end

  // cell payload, captured with the position it was taken at
  always_ff @(posedge clk) begin
    if (accept) begin
      rows[0]      <= in_data.row0_bits;
      rows[1]      <= in_data.row1_bits;
      rows[2]      <= in_data.row2_bits;
      rows[3]      <= in_data.row3_bits;
      rows[4]      <= in_data.row4_bits;
      rows[5]      <= in_data.row5_bits;
      rows[6]      <= in_data.row6_bits;
      rows[7]      <= in_data.row7_bits;
      set_color    <= swap ? paper : ink;
      clear_color  <= swap ? ink : paper;
      cell_col     <= column;
      cell_row     <= text_row;
      cell_is_last <= (column == LAST_COL) && (text_row == LAST_ROW);
    end
  end

  // one lane per microline
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    acpr_lane u_lane (
      .row_bits    (rows[g]),
      .bit_idx     (bit_idx),
      .set_color   (set_color),
      .clear_color (clear_color),
      .color       (lane_color[g])
    );
  end

  // x = column * 8 + bit, y = row * 8, both kept to 8 bits
  assign x_wide        = {cell_col, bit_idx};
  assign tag.x         = POS_W'(x_wide);
  assign tag.y         = POS_W'({cell_row, 3'b000});
  assign tag.cell_last = (bit_idx == LAST_BIT);
  assign tag.frame_end = (bit_idx == LAST_BIT) && cell_is_last;

  acpr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .strip_valid (cell_valid),
    .tag         (tag),
    .lane_color  (lane_color),
    .ready       (merge_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_cell : assert property (@(posedge clk) disable iff (rst)
    accept |=> cell_valid && (bit_idx == '0))
    else $error("accepted cell did not start at bit 0");

  a_frame_end_on_last : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.frame_end || out_data.cell_last))
    else $error("frame_end without cell_last");

  a_counters_in_range : assert property (@(posedge clk) disable iff (rst)
    (column <= LAST_COL) && (text_row <= LAST_ROW))
    else $error("position counter out of range");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (cell_valid && !merge_ready) |=> cell_valid && $stable(bit_idx))
    else $error("cell stage moved while output was blocked");

endmodule
